// File: rtl/core/tcos_pkg.sv
// Shared types and fixed-point constants for the range-reduced Taylor cosine.
// Depends on nothing; used by the front, queue, term, back and top-level files.
package tcos_pkg;

    localparam int TERM_COUNT  = 10;
    localparam int ANGLE_W     = 32;
    localparam int COS_W       = 32;
    localparam int QUEUE_DEPTH = 4;

    localparam longint PI_Q24     = 64'sd52707179;
    localparam longint TWO_PI_Q24 = 64'sd105414357;
    localparam longint U_OFS      = PI_Q24 + 32 * TWO_PI_Q24;

    localparam int U_W      = 33;
    localparam int UH_LSB   = 20;
    localparam int UH_W     = U_W - UH_LSB;
    localparam int RED_SH   = 36;
    localparam int RED_RCP  = int'(64'sd68719476736 / TWO_PI_Q24);
    localparam int RCP_W    = 10;
    localparam int QE_W     = 7;
    localparam int REM_W    = 28;
    localparam int T_W      = 27;
    localparam int SQ_W     = 2 * T_W;
    localparam int XX_W     = 44;

    localparam int MAG_W    = 44;
    localparam int SUM_W    = 48;
    localparam int HALF_W   = 22;
    localparam int P_W      = 88;
    localparam int G_W      = 46;
    localparam int FRAC_W   = 40;
    localparam int HI_W     = G_W - HALF_W;
    localparam int DIV_W    = 10;
    localparam int RES_SH   = 10;
    localparam int RES_W    = SUM_W - RES_SH;

    localparam logic [MAG_W-1:0]        ONE_MAG = MAG_W'(64'd1 << FRAC_W);
    localparam logic signed [SUM_W-1:0] ONE_SUM = SUM_W'(64'sd1 << FRAC_W);
    localparam logic signed [RES_W-1:0] ONE_RES = RES_W'(64'sd1 << 30);

    typedef struct packed {
        logic                    sign;
        logic [MAG_W-1:0]        mag;
        logic [XX_W-1:0]         xx;
        logic signed [SUM_W-1:0] sum;
    } tcos_state_t;

endpackage

// File: rtl/core/tcos_front.sv
// Front pipeline: range reduction of the angle to [-pi, pi) and squaring.
// Depends on tcos_pkg.
module tcos_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [tcos_pkg::ANGLE_W-1:0] angle,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [tcos_pkg::XX_W-1:0]    out_xx
);

    logic                          v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [tcos_pkg::U_W-1:0]      u1_reg, u2_reg;
    logic [tcos_pkg::QE_W-1:0]     qe2_reg;
    logic [tcos_pkg::REM_W-1:0]    rem3_reg;
    logic signed [tcos_pkg::T_W-1:0] t4_reg;
    logic [tcos_pkg::XX_W-1:0]     xx5_reg;

    logic                          en;
    logic [tcos_pkg::U_W-1:0]      u1_next;
    logic [tcos_pkg::UH_W+tcos_pkg::RCP_W-1:0] qprod;
    logic [tcos_pkg::QE_W-1:0]     qe2_next;
    logic [tcos_pkg::U_W:0]        qtimes;
    logic [tcos_pkg::U_W-1:0]      rem_full;
    logic [tcos_pkg::REM_W-1:0]    m_red;
    logic signed [tcos_pkg::REM_W-1:0] t_full;
    logic signed [tcos_pkg::SQ_W-1:0]  sq;

    assign en        = !v5_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = v5_reg;
    assign out_xx    = xx5_reg;

    assign u1_next  = {{(tcos_pkg::U_W-tcos_pkg::ANGLE_W){angle[tcos_pkg::ANGLE_W-1]}}, angle}
                    + tcos_pkg::U_W'(tcos_pkg::U_OFS);
    assign qprod    = u1_reg[tcos_pkg::U_W-1:tcos_pkg::UH_LSB]
                    * tcos_pkg::RCP_W'(tcos_pkg::RED_RCP);
    assign qe2_next = qprod[tcos_pkg::UH_W+tcos_pkg::RCP_W-1:tcos_pkg::RED_SH-tcos_pkg::UH_LSB];
    assign qtimes   = qe2_reg * (tcos_pkg::U_W+1)'(tcos_pkg::TWO_PI_Q24);
    assign rem_full = u2_reg - qtimes[tcos_pkg::U_W-1:0];
    assign m_red    = (rem3_reg >= tcos_pkg::REM_W'(tcos_pkg::TWO_PI_Q24))
                    ? rem3_reg - tcos_pkg::REM_W'(tcos_pkg::TWO_PI_Q24) : rem3_reg;
    assign t_full   = $signed(m_red) - $signed(tcos_pkg::REM_W'(tcos_pkg::PI_Q24));
    assign sq       = t4_reg * t4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            u1_reg   <= u1_next;
            u2_reg   <= u1_reg;
            qe2_reg  <= qe2_next;
            rem3_reg <= rem_full[tcos_pkg::REM_W-1:0];
            t4_reg   <= t_full[tcos_pkg::T_W-1:0];
            xx5_reg  <= sq[tcos_pkg::XX_W+7:8];
        end
    end

endmodule

// File: rtl/core/tcos_queue.sv
// Short FIFO of squared angles between the front and back pipelines.
// Depends on tcos_pkg.
module tcos_queue (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push_valid,
    output logic                     push_ready,
    input  logic [tcos_pkg::XX_W-1:0] push_data,
    output logic                     pop_valid,
    input  logic                     pop_ready,
    output logic [tcos_pkg::XX_W-1:0] pop_data
);

    localparam int PTR_W = $clog2(tcos_pkg::QUEUE_DEPTH);

    logic [tcos_pkg::XX_W-1:0] mem_reg [tcos_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]          wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]            count_reg, count_next;
    logic                      push, pop;

    assign push_ready = count_reg != (PTR_W+1)'(tcos_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/core/tcos_term.sv
// One series step: term = -(floor(term*xx/2^40) / ((2i-1)(2i))), sum += term.
// Six stages; depends on tcos_pkg.
module tcos_term #(
    parameter int STEP = 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  tcos_pkg::tcos_state_t in_st,
    output logic                  out_valid,
    output tcos_pkg::tcos_state_t out_st
);

    localparam int HW = tcos_pkg::HALF_W;
    localparam longint DIV = longint'((2 * STEP - 1) * (2 * STEP));
    localparam longint RCP = (64'sd1 << 32) / DIV;
    localparam logic [tcos_pkg::DIV_W-1:0] DIV_V = tcos_pkg::DIV_W'(DIV);
    localparam logic [31:0]                RCP_V = 32'(RCP);

    logic vp_reg, vs_reg, va_reg, vb_reg, vc_reg, vd_reg;
    tcos_pkg::tcos_state_t stp_reg, sts_reg, sta_reg, stb_reg, stc_reg, std_reg;
    logic [2*HW-1:0] pp00_reg, pp01_reg, pp10_reg, pp11_reg;
    logic [tcos_pkg::G_W-1:0]  g_reg;
    logic [tcos_pkg::HI_W-1:0] x1_reg, qe1_reg, q1b_reg, q1c_reg;
    logic [HW-1:0]             gloa_reg, glob_reg;
    logic [tcos_pkg::DIV_W-1:0] r1_reg;
    logic [31:0]               x2_reg;
    logic [HW-1:0]             qe2_reg;

    logic [tcos_pkg::P_W-1:0]  p;
    logic [tcos_pkg::G_W-1:0]  g_next;
    logic [tcos_pkg::HI_W+31:0] prod_a;
    logic [tcos_pkg::HI_W+tcos_pkg::DIV_W-1:0] qd1;
    logic [tcos_pkg::HI_W-1:0] r1w;
    logic [63:0]               prod_c;
    logic [31:0]               qd2, r2w, x2_next;
    logic [HW:0]               q2;
    logic [tcos_pkg::G_W-1:0]  q;
    logic signed [tcos_pkg::SUM_W-1:0] qs;
    tcos_pkg::tcos_state_t     std_next;

    assign p = (tcos_pkg::P_W'(pp11_reg) << (2 * HW))
             + (tcos_pkg::P_W'(pp01_reg) << HW)
             + (tcos_pkg::P_W'(pp10_reg) << HW)
             + tcos_pkg::P_W'(pp00_reg);
    assign g_next = p[tcos_pkg::FRAC_W+tcos_pkg::G_W-1:tcos_pkg::FRAC_W]
                  + tcos_pkg::G_W'(sts_reg.sign && (p[tcos_pkg::FRAC_W-1:0] != '0));

    assign prod_a = g_reg[tcos_pkg::G_W-1:HW] * RCP_V;
    assign qd1    = qe1_reg * DIV_V;
    assign r1w    = x1_reg - qd1[tcos_pkg::HI_W-1:0];
    assign x2_next = (r1w >= tcos_pkg::HI_W'(DIV_V))
                   ? {tcos_pkg::DIV_W'(r1w - tcos_pkg::HI_W'(DIV_V)), glob_reg}
                   : {r1w[tcos_pkg::DIV_W-1:0], glob_reg};
    assign prod_c = {r1_reg, glob_reg} * RCP_V;
    assign qd2    = qe2_reg * DIV_V;
    assign r2w    = x2_reg - qd2;
    assign q2     = (r2w >= 32'(DIV_V)) ? {1'b0, qe2_reg} + 1'b1 : {1'b0, qe2_reg};
    assign q      = {q1c_reg, {HW{1'b0}}} + tcos_pkg::G_W'(q2);
    assign qs     = $signed({{(tcos_pkg::SUM_W-tcos_pkg::G_W){1'b0}}, q});

    always_comb begin
        std_next      = stc_reg;
        std_next.sign = !stc_reg.sign;
        std_next.mag  = q[tcos_pkg::MAG_W-1:0];
        std_next.sum  = stc_reg.sign ? stc_reg.sum + qs : stc_reg.sum - qs;
    end

    assign out_valid = vd_reg;
    assign out_st    = std_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp_reg <= 1'b0;
            vs_reg <= 1'b0;
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else if (en) begin
            vp_reg <= in_valid;
            vs_reg <= vp_reg;
            va_reg <= vs_reg;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stp_reg  <= in_st;
            pp00_reg <= in_st.mag[HW-1:0]    * in_st.xx[HW-1:0];
            pp01_reg <= in_st.mag[HW-1:0]    * in_st.xx[2*HW-1:HW];
            pp10_reg <= in_st.mag[2*HW-1:HW] * in_st.xx[HW-1:0];
            pp11_reg <= in_st.mag[2*HW-1:HW] * in_st.xx[2*HW-1:HW];
            sts_reg  <= stp_reg;
            g_reg    <= g_next;
            sta_reg  <= sts_reg;
            x1_reg   <= g_reg[tcos_pkg::G_W-1:HW];
            qe1_reg  <= prod_a[tcos_pkg::HI_W+31:32];
            gloa_reg <= g_reg[HW-1:0];
            stb_reg  <= sta_reg;
            q1b_reg  <= (r1w >= tcos_pkg::HI_W'(DIV_V)) ? qe1_reg + 1'b1 : qe1_reg;
            r1_reg   <= x2_next[31:HW];
            glob_reg <= gloa_reg;
            stc_reg  <= stb_reg;
            x2_reg   <= {r1_reg, glob_reg};
            q1c_reg  <= q1b_reg;
            qe2_reg  <= prod_c[HW+31:32];
            std_reg  <= std_next;
        end
    end

endmodule

// File: rtl/core/tcos_back.sv
// Back pipeline: chain of series steps, final scaling, saturation, output register.
// Depends on tcos_pkg and tcos_term.
module tcos_back #(
    parameter int TERM_COUNT = tcos_pkg::TERM_COUNT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [tcos_pkg::XX_W-1:0] in_xx,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [tcos_pkg::COS_W-1:0] cosine
);

    logic                  en;
    logic                  v_arr [TERM_COUNT+1];
    tcos_pkg::tcos_state_t st_arr [TERM_COUNT+1];
    logic                  v0_reg;
    tcos_pkg::tcos_state_t st0_reg;
    logic                  out_valid_reg;
    logic [tcos_pkg::COS_W-1:0] cosine_reg;
    logic signed [tcos_pkg::RES_W-1:0] res, res_sat;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st0_reg.sign <= 1'b0;
            st0_reg.mag  <= tcos_pkg::ONE_MAG;
            st0_reg.xx   <= in_xx;
            st0_reg.sum  <= tcos_pkg::ONE_SUM;
        end
    end

    assign v_arr[0]  = v0_reg;
    assign st_arr[0] = st0_reg;

    for (genvar i = 0; i < TERM_COUNT; i++) begin : g_term
        tcos_term #(
            .STEP(i + 1)
        ) u_term (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (v_arr[i]),
            .in_st    (st_arr[i]),
            .out_valid(v_arr[i+1]),
            .out_st   (st_arr[i+1])
        );
    end

    assign res = st_arr[TERM_COUNT].sum[tcos_pkg::SUM_W-1:tcos_pkg::RES_SH];

    always_comb begin
        priority if (res > tcos_pkg::ONE_RES) begin
            res_sat = tcos_pkg::ONE_RES;
        end else if (res < -tcos_pkg::ONE_RES) begin
            res_sat = -tcos_pkg::ONE_RES;
        end else begin
            res_sat = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= v_arr[TERM_COUNT];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cosine_reg <= res_sat[tcos_pkg::COS_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign cosine    = cosine_reg;

endmodule

// File: rtl/core/taylor_cosine_with_reduction.sv
// Top level of the range-reduced Taylor cosine: front, queue and back pipelines.
// Depends on tcos_pkg, tcos_front, tcos_queue and tcos_back.
//
// Fully pipelined: one angle per clock is taken and one cosine per clock is given
// while m_tready stays high. An input transfer passes through 5 front stages,
// the queue, 1 + 6 * TERM_COUNT back stages and the output register, and may
// wait longer in any of them while the output stalls.
// Each series term costs six stages: split 44 x 44 multiply, sum, and a two-chunk
// divide by a constant through reciprocal multiplies. A four-entry queue lets
// the front keep taking angles while the back waits on m_tready, until it fills.
module taylor_cosine_with_reduction #(
    parameter int TERM_COUNT = tcos_pkg::TERM_COUNT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] angle
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] cosine
);

    logic                      f_valid, f_ready, b_valid, b_ready;
    logic [tcos_pkg::XX_W-1:0] f_xx, b_xx;

    tcos_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .angle    (s_tdata),
        .out_valid(f_valid),
        .out_ready(f_ready),
        .out_xx   (f_xx)
    );

    tcos_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(f_valid),
        .push_ready(f_ready),
        .push_data (f_xx),
        .pop_valid (b_valid),
        .pop_ready (b_ready),
        .pop_data  (b_xx)
    );

    tcos_back #(
        .TERM_COUNT(TERM_COUNT)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (b_valid),
        .in_ready (b_ready),
        .in_xx    (b_xx),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .cosine   (m_tdata)
    );

endmodule

// File: rtl/core/tcos_checker.sv
// Port-level checks for taylor_cosine_with_reduction, bound to the top level.
// Depends on the top level's port list only.
module tcos_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata) <= 32'sd1073741824
                   && $signed(m_tdata) >= -32'sd1073741824))
        else $error("cosine outside of plus or minus one");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output transfer changed");

endmodule

bind taylor_cosine_with_reduction tcos_checker u_tcos_checker (.*);
